// ===== design/fblr_pkg.sv =====
`default_nettype none
package fblr_pkg;

    localparam int MAX_W       = 128;
    localparam int MAX_H       = 160;
    localparam int MEM_DEPTH   = MAX_W * MAX_H;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int DIM_W       = 9;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_W);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_H);

    localparam logic [7:0] PIC_WIDTH_RESET  = 8'd128;
    localparam logic [7:0] PIC_HEIGHT_RESET = 8'd160;

    localparam logic CFG_PIC_WIDTH  = 1'b0;
    localparam logic CFG_PIC_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        CMD_LINE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [15:0] color;
    } t_in_word;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [8:0]  points_written;
    } t_out_word;

    // A classified command as the back end consumes it.
    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  x0;
        logic [7:0]  y0;
        logic        x_neg;
        logic        y_neg;
        logic [7:0]  dx;
        logic [7:0]  dy;
        logic [7:0]  major;
        logic [15:0] color;
    } t_job;

endpackage
`default_nettype wire

// ===== design/fblr_front.sv =====
`default_nettype none
module fblr_front
    import fblr_pkg::*;
(
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_word i_word,
    output logic          o_push,
    output t_job          o_job,
    input  wire logic     i_full
);

    logic [7:0] w_dx;
    logic [7:0] w_dy;
    logic       w_x_neg;
    logic       w_y_neg;
    t_cmd       w_cmd;

    assign w_cmd   = t_cmd'(i_word.command);
    assign w_x_neg = i_word.x_end < i_word.x_start;
    assign w_y_neg = i_word.y_end < i_word.y_start;
    assign w_dx    = w_x_neg ? i_word.x_start - i_word.x_end : i_word.x_end - i_word.x_start;
    assign w_dy    = w_y_neg ? i_word.y_start - i_word.y_end : i_word.y_end - i_word.y_start;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // A single point write runs through the stepper as a line of length zero.
    always_comb begin
        o_job.cmd   = w_cmd;
        o_job.x0    = i_word.x_start;
        o_job.y0    = i_word.y_start;
        o_job.color = i_word.color;
        o_job.x_neg = 1'b0;
        o_job.y_neg = 1'b0;
        o_job.dx    = 8'd0;
        o_job.dy    = 8'd0;
        o_job.major = 8'd0;
        case (w_cmd)
            CMD_LINE: begin
                o_job.x_neg = w_x_neg;
                o_job.y_neg = w_y_neg;
                o_job.dx    = w_dx;
                o_job.dy    = w_dy;
                o_job.major = (w_dx > w_dy) ? w_dx : w_dy;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/fblr_queue.sv =====
`default_nettype none
module fblr_queue
    import fblr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== design/fblr_back.sv =====
`default_nettype none
module fblr_back
    import fblr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire t_job       i_job,
    input  wire logic       i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_word       o_word
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINE,
        S_READ,
        S_DONE
    } t_state;

    t_state      r_state;
    logic [7:0]  r_pic_width;
    logic [7:0]  r_pic_height;
    t_cmd        r_cmd;
    logic [7:0]  r_px;
    logic [7:0]  r_py;
    logic [7:0]  r_ex;
    logic [7:0]  r_ey;
    logic        r_x_neg;
    logic        r_y_neg;
    logic [7:0]  r_dx;
    logic [7:0]  r_dy;
    logic [7:0]  r_dist;
    logic [7:0]  r_left;
    logic [15:0] r_color;
    logic [8:0]  r_cnt;
    logic        r_rd_ok;
    logic [15:0] r_rd_data;
    logic        r_out_valid;
    t_out_word   r_out;
    logic [15:0] r_mem [MEM_DEPTH];

    logic [DIM_W-1:0] w_w_eff;
    logic [DIM_W-1:0] w_h_eff;
    logic             w_inb;
    logic [16:0]      w_prod;
    logic [ADDR_W-1:0] w_addr;
    logic             w_we;
    logic [8:0]       w_ex_sum;
    logic [8:0]       w_ey_sum;
    logic             w_out_free;

    assign w_w_eff = ({1'b0, r_pic_width} > MAX_W_DIM) ? MAX_W_DIM : {1'b0, r_pic_width};
    assign w_h_eff = ({1'b0, r_pic_height} > MAX_H_DIM) ? MAX_H_DIM : {1'b0, r_pic_height};
    assign w_inb   = ({1'b0, r_px} < w_w_eff) && ({1'b0, r_py} < w_h_eff);

    // In bounds the address always stays below the store depth.
    assign w_prod  = {9'd0, r_py} * {8'd0, w_w_eff};
    assign w_addr  = ADDR_W'(w_prod + {9'd0, r_px});
    assign w_we    = (r_state == S_LINE) && w_inb;

    assign w_ex_sum   = {1'b0, r_ex} + {1'b0, r_dx};
    assign w_ey_sum   = {1'b0, r_ey} + {1'b0, r_dy};
    assign w_out_free = !r_out_valid || !i_stall;

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= r_color;
        end
        r_rd_data <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pic_width  <= PIC_WIDTH_RESET;
            r_pic_height <= PIC_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PIC_WIDTH:  r_pic_width  <= i_cfg_data;
                CFG_PIC_HEIGHT: r_pic_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A finished job refills the output register as the old word leaves.
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_job.cmd;
                        r_px    <= i_job.x0;
                        r_py    <= i_job.y0;
                        r_ex    <= i_job.dx;
                        r_ey    <= i_job.dy;
                        r_dx    <= i_job.dx;
                        r_dy    <= i_job.dy;
                        r_x_neg <= i_job.x_neg;
                        r_y_neg <= i_job.y_neg;
                        r_dist  <= i_job.major;
                        r_left  <= i_job.major;
                        r_color <= i_job.color;
                        r_cnt   <= 9'd0;
                        r_rd_ok <= 1'b0;
                        case (i_job.cmd)
                            CMD_LINE, CMD_WRITE: r_state <= S_LINE;
                            CMD_READ:            r_state <= S_READ;
                            default:             r_state <= S_DONE;
                        endcase
                    end
                end
                S_LINE: begin
                    // One point per cycle; an axis steps when its error passes the distance.
                    r_cnt <= r_cnt + {8'd0, w_inb};
                    if (w_ex_sum > {1'b0, r_dist}) begin
                        r_ex <= 8'(w_ex_sum - {1'b0, r_dist});
                        r_px <= r_x_neg ? r_px - 8'd1 : r_px + 8'd1;
                    end else begin
                        r_ex <= 8'(w_ex_sum);
                    end
                    if (w_ey_sum > {1'b0, r_dist}) begin
                        r_ey <= 8'(w_ey_sum - {1'b0, r_dist});
                        r_py <= r_y_neg ? r_py - 8'd1 : r_py + 8'd1;
                    end else begin
                        r_ey <= 8'(w_ey_sum);
                    end
                    if (r_left == 8'd0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_left <= r_left - 8'd1;
                    end
                end
                S_READ: begin
                    r_rd_ok <= w_inb;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out.points_written <= r_cnt;
                        r_out.pixel_value    <= ((r_cmd == CMD_READ) && r_rd_ok) ?
                                                r_rd_data : 16'd0;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && !i_empty)
        else $error("job taken outside idle");
    a_line_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINE) && (r_left == 8'd0) |=> r_state == S_DONE)
        else $error("line did not finish after its last point");
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && w_out_free |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished result not loaded into the output register");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.points_written <= 9'd256)
        else $error("point count beyond a full line");

endmodule
`default_nettype wire

// ===== design/framebuffer_line_raster_unit.sv =====
`default_nettype none
// Port group    | Signals                               | Direction
// input words   | i_valid, o_stall, i_word              | in
// result words  | o_valid, i_stall, o_word              | out
// configuration | i_cfg_we, i_cfg_index, i_cfg_data     | in
//
// In the back end a line takes the job, then steps one point at a time, dist+1 points
// with dist the larger of |dx| and |dy|, through the single frame store write port, and
// loads the result. A point write is a one-point line; a read reads the store instead.
// Reset is synchronous and clears control state only; the frame store is not cleared.
// A four-word queue lets input words be taken while the back end is busy or its
// result is stalled.
module framebuffer_line_raster_unit
    import fblr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire t_in_word   i_word,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_out_word       o_word,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;
    t_job w_push_job;
    t_job w_head_job;

    fblr_front u_front (
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_full)
    );

    fblr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_empty (w_empty)
    );

    fblr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_job       (w_head_job),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word)
    );

endmodule
`default_nettype wire

// ===== tb/framebuffer_line_raster_checker.sv =====
`timescale 1ns / 1ps
module framebuffer_line_raster_checker
    import fblr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire t_in_word   i_in_word,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_out_word  i_out_word,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output int              o_mismatches,
    output int              o_outstanding
);

    logic [15:0] frame_px [MEM_DEPTH];
    t_out_word   results_due [$];
    int          area_w;
    int          area_h;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        area_w        = MAX_W;
        area_h        = MAX_H;
    end

    // Store address of a pixel, or -1 when it lies outside the area in use.
    function automatic int px_addr(input int x, input int y);
        if (x < 0 || y < 0 || x >= area_w || y >= area_h) begin
            return -1;
        end
        return y * area_w + x;
    endfunction

    // Applies one input word to the frame copy and returns the result word it gives.
    function automatic t_out_word predict_result(input t_in_word wd);
        t_out_word r;
        int dx, dy, sx, sy, major, ex, ey, px, py, a, k, cnt;
        r   = '0;
        cnt = 0;
        case (t_cmd'(wd.command))
            CMD_LINE: begin
                dx = int'(wd.x_end) - int'(wd.x_start);
                dy = int'(wd.y_end) - int'(wd.y_start);
                sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
                sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                major = (dx > dy) ? dx : dy;
                // The first accumulation never moves an axis, so the errors start preloaded.
                ex = dx;
                ey = dy;
                px = int'(wd.x_start);
                py = int'(wd.y_start);
                for (k = 0; k <= major; k++) begin
                    a = px_addr(px, py);
                    if (a >= 0) begin
                        frame_px[a] = wd.color;
                        cnt++;
                    end
                    ex += dx;
                    ey += dy;
                    if (ex > major) begin
                        ex -= major;
                        px += sx;
                    end
                    if (ey > major) begin
                        ey -= major;
                        py += sy;
                    end
                end
            end
            CMD_WRITE: begin
                a = px_addr(int'(wd.x_start), int'(wd.y_start));
                if (a >= 0) begin
                    frame_px[a] = wd.color;
                    cnt = 1;
                end
            end
            CMD_READ: begin
                a = px_addr(int'(wd.x_start), int'(wd.y_start));
                if (a >= 0) r.pixel_value = frame_px[a];
            end
            default: ;
        endcase
        r.points_written = 9'(cnt);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            results_due.delete();
            area_w = (int'(PIC_WIDTH_RESET) > MAX_W) ? MAX_W : int'(PIC_WIDTH_RESET);
            area_h = (int'(PIC_HEIGHT_RESET) > MAX_H) ? MAX_H : int'(PIC_HEIGHT_RESET);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PIC_WIDTH) begin
                    area_w = (int'(i_cfg_data) > MAX_W) ? MAX_W : int'(i_cfg_data);
                end else begin
                    area_h = (int'(i_cfg_data) > MAX_H) ? MAX_H : int'(i_cfg_data);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result word with none expected, got %h", $time, i_out_word);
                    o_mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_out_word.pixel_value !== want.pixel_value) begin
                        $display("%0t: pixel_value expected %h, got %h", $time,
                                 want.pixel_value, i_out_word.pixel_value);
                        o_mismatches++;
                    end
                    if (i_out_word.points_written !== want.points_written) begin
                        $display("%0t: points_written expected %0d, got %0d", $time,
                                 want.points_written, i_out_word.points_written);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(predict_result(i_in_word));
            end
        end
        o_outstanding = results_due.size();
    end

endmodule

// ===== tb/framebuffer_line_raster_unit_tb.sv =====
`timescale 1ns / 1ps
module framebuffer_line_raster_unit_tb;
    import fblr_pkg::*;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in_word   in_word   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_PIC_WIDTH;
    logic [7:0] cfg_data  = '0;
    logic       in_stall;
    logic       out_valid;
    t_out_word  out_word;
    int         mismatches;
    int         outstanding;

    // Idle odds in percent for each side, changed per phase.
    int send_gap  = 0;
    int recv_hold = 0;

    // Area in use as last programmed, and which store entries hold a color.
    int area_w = MAX_W;
    int area_h = MAX_H;
    bit px_written [MEM_DEPTH];
    int recent_px [$];

    framebuffer_line_raster_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_word      (in_word),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_word      (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    framebuffer_line_raster_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_word     (in_word),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_word    (out_word),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_hold);
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_in_word pack_word(input t_cmd cmd, input int xs, input int ys,
                                           input int xe, input int ye, input int c);
        t_in_word wd;
        wd.command = cmd;
        wd.x_start = 8'(xs);
        wd.y_start = 8'(ys);
        wd.x_end   = 8'(xe);
        wd.y_end   = 8'(ye);
        wd.color   = 16'(c);
        return wd;
    endfunction

    function automatic void mark_point(input int x, input int y);
        if (x < area_w && y < area_h) begin
            px_written[y * area_w + x] = 1'b1;
            recent_px.push_back(y * area_w + x);
            if (recent_px.size() > 512) void'(recent_px.pop_front());
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input t_in_word wd);
        int dx, dy, sx, sy, ax, ay, n, k;
        if (wd.command == CMD_WRITE) begin
            mark_point(int'(wd.x_start), int'(wd.y_start));
        end else if (wd.command == CMD_LINE) begin
            dx = int'(wd.x_end) - int'(wd.x_start);
            dy = int'(wd.y_end) - int'(wd.y_start);
            sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
            sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            // Only straight and 45 degree lines have every point known here;
            // other lines are known to hold their two endpoints.
            if (ax == 0 || ay == 0 || ax == ay) begin
                n = (ax > ay) ? ax : ay;
                for (k = 0; k <= n; k++) begin
                    mark_point(int'(wd.x_start) + sx * k, int'(wd.y_start) + sy * k);
                end
            end else begin
                mark_point(int'(wd.x_start), int'(wd.y_start));
                mark_point(int'(wd.x_end), int'(wd.y_end));
            end
        end
        while ($urandom_range(99) < send_gap) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= wd;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic load_geometry(input int w, input int h);
        wait_idle(4);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PIC_WIDTH;
        cfg_data  <= 8'(w);
        @(negedge clk);
        cfg_index <= CFG_PIC_HEIGHT;
        cfg_data  <= 8'(h);
        @(negedge clk);
        cfg_we <= 1'b0;
        area_w = (w > MAX_W) ? MAX_W : w;
        area_h = (h > MAX_H) ? MAX_H : h;
    endtask

    initial begin
        t_in_word wd;
        int ph, n, n_items, pick, kind, xs, ys, xe, ye, len, sx, sy, a, span_x, span_y;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_gap  = 26;
        recv_hold = 63;
        // Directed words at the reset geometry of 128 by 160.
        send_word(pack_word(CMD_WRITE, 0, 0, 0, 0, 'hFFFF));
        send_word(pack_word(CMD_WRITE, 127, 159, 0, 0, 'h0000));
        send_word(pack_word(CMD_WRITE, 128, 0, 0, 0, 'h1111));
        send_word(pack_word(CMD_WRITE, 0, 160, 0, 0, 'h2222));
        send_word(pack_word(CMD_WRITE, 255, 255, 255, 255, 'hAAAA));
        send_word(pack_word(CMD_READ, 0, 0, 0, 0, 0));
        send_word(pack_word(CMD_READ, 127, 159, 255, 255, 'hFFFF));
        send_word(pack_word(CMD_READ, 255, 255, 0, 0, 0));
        send_word(pack_word(CMD_NOP, 3, 4, 5, 6, 'h5A5A));
        send_word(pack_word(CMD_LINE, 0, 0, 0, 0, 'h5555));
        send_word(pack_word(CMD_LINE, 0, 10, 127, 10, 'h1234));
        send_word(pack_word(CMD_LINE, 5, 0, 5, 159, 'h8001));
        send_word(pack_word(CMD_LINE, 100, 100, 0, 0, 'h7FFE));
        send_word(pack_word(CMD_LINE, 0, 20, 255, 40, 'hC3C3));
        send_word(pack_word(CMD_LINE, 120, 159, 3, 2, 'h3C3C));
        send_word(pack_word(CMD_LINE, 255, 0, 0, 255, 'h0F0F));
        send_word(pack_word(CMD_LINE, 0, 255, 255, 0, 'hF0F0));
        send_word(pack_word(CMD_LINE, 255, 255, 200, 100, 'hBEEF));
        send_word(pack_word(CMD_READ, 64, 10, 0, 0, 0));
        send_word(pack_word(CMD_READ, 5, 159, 0, 0, 0));
        send_word(pack_word(CMD_READ, 50, 50, 0, 0, 0));
        send_word(pack_word(CMD_NOP, 255, 255, 255, 255, 'hFFFF));

        for (ph = 0; ph < 6; ph++) begin
            send_gap  = (ph < 2) ? 26 : ((ph < 4) ? 63 : 0);
            recv_hold = (ph < 2) ? 63 : ((ph < 4) ? 26 : 0);
            case (ph)
                0: load_geometry(128, 160);
                1: load_geometry(0, 160);
                2: load_geometry(255, 1);
                3: load_geometry(1, 255);
                4: load_geometry(128, 0);
                default: load_geometry($urandom_range(2, 127), $urandom_range(2, 159));
            endcase
            // An empty area clips everything, so those phases are kept short.
            n_items = (area_w == 0 || area_h == 0) ? 100 : 250;
            span_x  = (area_w + 8 > 255) ? 255 : area_w + 8;
            span_y  = (area_h + 8 > 255) ? 255 : area_h + 8;
            for (n = 0; n < n_items; n++) begin
                wd.color = 16'($urandom);
                wd.x_end = 8'($urandom);
                wd.y_end = 8'($urandom);
                xs = $urandom_range(span_x);
                ys = $urandom_range(span_y);
                if ($urandom_range(9) == 0) begin
                    xs = $urandom_range(255);
                    ys = $urandom_range(255);
                end
                pick = $urandom_range(99);
                if (pick < 45) begin
                    wd.command = CMD_LINE;
                    case ($urandom_range(3))
                        0: begin
                            xe = xs + int'($urandom_range(24)) - 12;
                            ye = ys + int'($urandom_range(24)) - 12;
                            xe = (xe < 0) ? 0 : ((xe > 255) ? 255 : xe);
                            ye = (ye < 0) ? 0 : ((ye > 255) ? 255 : ye);
                        end
                        1: begin
                            len  = ($urandom_range(7) == 0) ? $urandom_range(255)
                                                            : $urandom_range(40);
                            kind = $urandom_range(2);
                            sx   = ($urandom_range(1) == 1) ? 1 : -1;
                            sy   = ($urandom_range(1) == 1) ? 1 : -1;
                            if (kind == 0) sy = 0;
                            if (kind == 1) sx = 0;
                            if (sx > 0 && xs + len > 255) len = 255 - xs;
                            if (sx < 0 && len > xs) len = xs;
                            if (sy > 0 && ys + len > 255) len = 255 - ys;
                            if (sy < 0 && len > ys) len = ys;
                            xe = xs + sx * len;
                            ye = ys + sy * len;
                        end
                        2: begin
                            xe = $urandom_range(span_x);
                            ye = $urandom_range(span_y);
                        end
                        default: begin
                            xe = $urandom_range(255);
                            ye = $urandom_range(255);
                        end
                    endcase
                    wd.x_end = 8'(xe);
                    wd.y_end = 8'(ye);
                end else if (pick < 70) begin
                    wd.command = CMD_WRITE;
                end else if (pick < 95) begin
                    wd.command = CMD_READ;
                    if (area_w > 0 && recent_px.size() > 0 && $urandom_range(9) < 7) begin
                        a  = recent_px[$urandom_range(recent_px.size() - 1)];
                        xs = a % area_w;
                        ys = a / area_w;
                        if (ys > 255) ys = 255;
                    end
                    // A pixel that never got a color is read from outside the area instead.
                    if (xs < area_w && ys < area_h && !px_written[ys * area_w + xs]) begin
                        xs = 255;
                    end
                end else begin
                    wd.command = CMD_NOP;
                end
                wd.x_start = 8'(xs);
                wd.y_start = 8'(ys);
                send_word(wd);
            end
        end

        wait_idle(300);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
